### design/smp_pkg.sv
// Shared types and constants of the STUN message parser.
`timescale 1ns / 1ps
`default_nettype none

package smp_pkg;

    localparam logic [31:0] MAGIC_COOKIE = 32'h2112_A442;
    localparam logic [16:0] HEADER_BYTES = 17'd20;
    localparam logic [16:0] COUNT_MAX    = 17'h1_FFFF;

    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_VALUE   = 2'd1;
    localparam logic [1:0] KIND_VERDICT = 2'd2;

    localparam logic [2:0] REASON_NONE    = 3'd0;
    localparam logic [2:0] REASON_SHORT   = 3'd1;
    localparam logic [2:0] REASON_COOKIE  = 3'd2;
    localparam logic [2:0] REASON_LENGTH  = 3'd3;
    localparam logic [2:0] REASON_HDR_CUT = 3'd4;
    localparam logic [2:0] REASON_OVERRUN = 3'd5;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } t_in;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] attr_type;
        logic [15:0] attr_length;
        logic [16:0] attr_offset;
        logic [7:0]  value_byte;
        logic        ok;
        logic [2:0]  fail_reason;
        logic [11:0] msg_method;
        logic [1:0]  msg_class;
        logic [31:0] txn_high;
        logic [63:0] txn_low;
        logic        run_end;
    } t_out;

    // Work handed from the classifier to the output side for one request.
    typedef struct packed {
        logic        has_rec;
        logic        rec_is_value;
        logic [15:0] attr_type;
        logic [15:0] attr_length;
        logic [16:0] attr_offset;
        logic [7:0]  value_byte;
        logic        has_verdict;
        logic [2:0]  reason;
        logic [11:0] msg_method;
        logic [1:0]  msg_class;
        logic [31:0] txn_high;
        logic [63:0] txn_low;
    } t_job;

endpackage

`default_nettype wire

### design/smp_front.sv
// Byte classifier: header capture, attribute walk and verdict decision.
`timescale 1ns / 1ps
`default_nettype none

module smp_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire smp_pkg::t_in  i_data,
    input  wire logic          i_full,
    output logic               o_push,
    output smp_pkg::t_job      o_job
);

    logic [16:0] r_byte_count, n_byte_count;
    logic [15:0] r_decl_len, n_decl_len;
    logic [15:0] r_type_word, n_type_word;
    logic [31:0] r_cookie, n_cookie;
    logic [31:0] r_txn_hi, n_txn_hi;
    logic [63:0] r_txn_lo, n_txn_lo;
    logic [1:0]  r_phase, n_phase;
    logic [31:0] r_head, n_head;
    logic [15:0] r_value_left, n_value_left;
    logic [1:0]  r_pad_left, n_pad_left;
    logic [16:0] r_attr_start, n_attr_start;
    logic [2:0]  r_fail, n_fail;
    logic        accept;
    logic [7:0]  b;
    logic [2:0]  reason;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;
    assign b       = i_data.data_byte;
    assign o_push  = accept && (o_job.has_rec || o_job.has_verdict);

    always_comb begin
        n_byte_count = r_byte_count;
        n_decl_len   = r_decl_len;
        n_type_word  = r_type_word;
        n_cookie     = r_cookie;
        n_txn_hi     = r_txn_hi;
        n_txn_lo     = r_txn_lo;
        n_phase      = r_phase;
        n_head       = r_head;
        n_value_left = r_value_left;
        n_pad_left   = r_pad_left;
        n_attr_start = r_attr_start;
        n_fail       = r_fail;
        o_job        = '0;
        reason       = smp_pkg::REASON_NONE;

        if (r_byte_count < 17'd2) begin
            n_type_word = {r_type_word[7:0], b};
        end else if (r_byte_count < 17'd4) begin
            n_decl_len = {r_decl_len[7:0], b};
        end else if (r_byte_count < 17'd8) begin
            n_cookie = {r_cookie[23:0], b};
            if (r_byte_count == 17'd7 && n_cookie != smp_pkg::MAGIC_COOKIE) begin
                n_fail = smp_pkg::REASON_COOKIE;
            end
        end else if (r_byte_count < 17'd12) begin
            n_txn_hi = {r_txn_hi[23:0], b};
        end else if (r_byte_count < smp_pkg::HEADER_BYTES) begin
            n_txn_lo = {r_txn_lo[55:0], b};
        end else if (r_value_left != 16'd0) begin
            o_job.has_rec      = 1'b1;
            o_job.rec_is_value = 1'b1;
            o_job.value_byte   = b;
            n_value_left       = r_value_left - 16'd1;
            if (n_value_left == 16'd0) begin
                n_pad_left = 2'd0 - r_head[1:0];
            end
        end else if (r_pad_left != 2'd0) begin
            n_pad_left = r_pad_left - 2'd1;
        end else begin
            if (r_phase == 2'd0) begin
                n_attr_start = r_byte_count;
            end
            n_head = {r_head[23:0], b};
            if (r_phase == 2'd3) begin
                n_phase       = 2'd0;
                o_job.has_rec = 1'b1;
                n_value_left  = n_head[15:0];
                n_pad_left    = 2'd0;
            end else begin
                n_phase = r_phase + 2'd1;
            end
        end

        if (r_byte_count != smp_pkg::COUNT_MAX) begin
            n_byte_count = r_byte_count + 17'd1;
        end

        o_job.attr_type   = n_head[31:16];
        o_job.attr_length = n_head[15:0];
        o_job.attr_offset = n_attr_start;

        if (i_data.final_byte) begin
            if (n_byte_count < smp_pkg::HEADER_BYTES) begin
                reason = smp_pkg::REASON_SHORT;
            end else if (n_fail != smp_pkg::REASON_NONE) begin
                reason = n_fail;
            end else if ({1'b0, n_decl_len} + smp_pkg::HEADER_BYTES != n_byte_count) begin
                reason = smp_pkg::REASON_LENGTH;
            end else if (n_phase != 2'd0) begin
                reason = smp_pkg::REASON_HDR_CUT;
            end else if (n_value_left != 16'd0) begin
                reason = smp_pkg::REASON_OVERRUN;
            end
            o_job.has_verdict = 1'b1;
            o_job.reason      = reason;
            if (reason == smp_pkg::REASON_NONE) begin
                o_job.msg_method = {n_type_word[13:9], n_type_word[7:5], n_type_word[3:0]};
                o_job.msg_class  = {n_type_word[8], n_type_word[4]};
                o_job.txn_high   = n_txn_hi;
                o_job.txn_low    = n_txn_lo;
            end
            n_byte_count = '0;
            n_decl_len   = '0;
            n_type_word  = '0;
            n_cookie     = '0;
            n_txn_hi     = '0;
            n_txn_lo     = '0;
            n_phase      = '0;
            n_head       = '0;
            n_value_left = '0;
            n_pad_left   = '0;
            n_attr_start = '0;
            n_fail       = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= '0;
            r_decl_len   <= '0;
            r_type_word  <= '0;
            r_cookie     <= '0;
            r_txn_hi     <= '0;
            r_txn_lo     <= '0;
            r_phase      <= '0;
            r_head       <= '0;
            r_value_left <= '0;
            r_pad_left   <= '0;
            r_attr_start <= '0;
            r_fail       <= '0;
        end else if (accept) begin
            r_byte_count <= n_byte_count;
            r_decl_len   <= n_decl_len;
            r_type_word  <= n_type_word;
            r_cookie     <= n_cookie;
            r_txn_hi     <= n_txn_hi;
            r_txn_lo     <= n_txn_lo;
            r_phase      <= n_phase;
            r_head       <= n_head;
            r_value_left <= n_value_left;
            r_pad_left   <= n_pad_left;
            r_attr_start <= n_attr_start;
            r_fail       <= n_fail;
        end
    end

endmodule

`default_nettype wire

### design/smp_queue.sv
// Short job queue between the classifier and the output side.
`timescale 1ns / 1ps
`default_nettype none

module smp_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire smp_pkg::t_job i_job,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_valid,
    output smp_pkg::t_job      o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    smp_pkg::t_job    r_slots [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_head  = r_slots[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slots[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

### design/smp_back.sv
// Output side: turns each job into one or two results in an output register.
`timescale 1ns / 1ps
`default_nettype none

module smp_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_job_valid,
    input  wire smp_pkg::t_job i_job,
    output logic               o_pop,
    output logic               o_valid,
    input  wire logic          i_ready,
    output smp_pkg::t_out      o_result
);

    logic          r_out_valid, n_out_valid;
    logic          r_second, n_second;
    smp_pkg::t_out r_out, n_out;
    logic          load;

    assign load     = !r_out_valid || i_ready;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_comb begin
        n_out_valid = r_out_valid;
        n_second    = r_second;
        n_out       = r_out;
        o_pop       = 1'b0;
        if (load) begin
            n_out_valid = 1'b0;
            if (i_job_valid) begin
                n_out_valid = 1'b1;
                n_out       = '0;
                if (i_job.has_rec && !r_second) begin
                    n_out.kind        = i_job.rec_is_value ? smp_pkg::KIND_VALUE
                                                           : smp_pkg::KIND_HEADER;
                    n_out.attr_type   = i_job.attr_type;
                    n_out.attr_length = i_job.attr_length;
                    n_out.attr_offset = i_job.attr_offset;
                    n_out.value_byte  = i_job.value_byte;
                    n_out.run_end     = !i_job.has_verdict;
                    if (i_job.has_verdict) begin
                        n_second = 1'b1;
                    end else begin
                        o_pop = 1'b1;
                    end
                end else begin
                    n_out.kind        = smp_pkg::KIND_VERDICT;
                    n_out.ok          = (i_job.reason == smp_pkg::REASON_NONE);
                    n_out.fail_reason = i_job.reason;
                    n_out.msg_method  = i_job.msg_method;
                    n_out.msg_class   = i_job.msg_class;
                    n_out.txn_high    = i_job.txn_high;
                    n_out.txn_low     = i_job.txn_low;
                    n_out.run_end     = 1'b1;
                    n_second          = 1'b0;
                    o_pop             = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_second    <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            r_second    <= n_second;
        end
    end

endmodule

`default_nettype wire

### design/stun_message_parser.sv
// Top level of the STUN message parser.
`timescale 1ns / 1ps
`default_nettype none

// The parser takes STUN packet bytes, with the last byte marked, and
// reports one record per attribute header, one per attribute value byte
// and a verdict on the last byte. A request is taken in every cycle while the
// job queue has room; a byte that yields both an attribute record and the
// verdict gives two results, and the QUEUE_DEPTH-entry queue between the
// classifier and the output register absorbs that. When nothing waits, a
// result is held in a queue slot, then in the output register. Records ahead
// of a failing verdict are still delivered and must be discarded downstream.
module stun_message_parser #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire smp_pkg::t_in  i_data,
    output logic               o_valid,
    input  wire logic          i_ready,
    output smp_pkg::t_out      o_result
);

    smp_pkg::t_job push_job, head_job;
    logic          push, full, head_valid, pop;

    smp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .i_full  (full),
        .o_push  (push),
        .o_job   (push_job)
    );

    smp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_head  (head_job)
    );

    smp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (head_valid),
        .i_job       (head_job),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_result    (o_result)
    );

`ifndef NO_ASSERTIONS
    a_verdict_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.kind == smp_pkg::KIND_VERDICT |-> o_result.run_end)
        else $error("verdict is not the last result of its request");

    a_ok_is_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.ok |->
            o_result.kind == smp_pkg::KIND_VERDICT &&
            o_result.fail_reason == smp_pkg::REASON_NONE)
        else $error("ok flag outside a clean verdict");

    a_fail_hides_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_result.ok |->
            o_result.txn_high == 32'd0 && o_result.txn_low == 64'd0 &&
            o_result.msg_method == 12'd0)
        else $error("transaction id shown without an ok verdict");
`endif

endmodule

`default_nettype wire
